FILE: hw/rtl/sit_pkg.sv
// sorted index table package: entry type, command and status codes
// used by the table control, the generic RAM user and the port checker
`default_nettype none

package sit_pkg;

   localparam int KEY_W    = 32;
   localparam int OFF_W    = 48;
   localparam int POS_W    = 6;
   localparam int TOTAL_W  = 7;
   localparam int STATUS_W = 3;
   localparam int CMD_W    = 2;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [OFF_W-1:0]        offset;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
   // spare code, answered with ok and no table change
   localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

   localparam logic signed [KEY_W-1:0] NULL_KEY = -32'sd1;

   // cap on results of one search
   localparam logic [TOTAL_W-1:0] MAX_RESULTS = 7'd64;

endpackage

`default_nettype wire

FILE: hw/rtl/sit_ram.sv
// generic single write, single read RAM with registered read data
// no dependencies; read data holds while no read is issued
`default_nettype none

module sit_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_index_table.sv
// sorted index table: insert reads and moves entries up one at a time until its slot is
// found, then writes the new entry; delete moves the entries above the position down one
// at a time; search does a binary search, then reads the run of matches and emits one item
// per match; rejected items go straight to their result. one item at a time: the next is
// taken in the cycle after the last result is registered; result stalls hold progress.
// reset clears the state, the entry count and the result valid; the entry RAM is not cleared
`default_nettype none

module sorted_index_table #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [sit_pkg::CMD_W-1:0]       req_command,
   input  wire logic signed [sit_pkg::KEY_W-1:0] req_key,
   input  wire logic [sit_pkg::OFF_W-1:0]       req_byte_offset,
   input  wire logic [sit_pkg::POS_W-1:0]       req_position,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [sit_pkg::STATUS_W-1:0]         rsp_status,
   output logic [sit_pkg::OFF_W-1:0]            rsp_match_offset,
   output logic [sit_pkg::POS_W-1:0]            rsp_match_position,
   output logic [sit_pkg::TOTAL_W-1:0]          rsp_entry_total,
   output logic                                 rsp_last
);

   import sit_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_INS_RD   = 10'b00_0000_0010,
      S_INS_CMP  = 10'b00_0000_0100,
      S_SRCH_RD  = 10'b00_0000_1000,
      S_SRCH_CMP = 10'b00_0001_0000,
      S_RUN_RD   = 10'b00_0010_0000,
      S_RUN_CMP  = 10'b00_0100_0000,
      S_DEL_RD   = 10'b00_1000_0000,
      S_DEL_WR   = 10'b01_0000_0000,
      S_FIN      = 10'b10_0000_0000
   } state_type;

   state_type st_ff, st_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [OFF_W-1:0]        boff_ff, boff_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [CW-1:0]           lo_ff, lo_in;
   logic [CW-1:0]           hi_ff, hi_in;
   logic [TOTAL_W-1:0]      n_ff, n_in;
   logic                    has_ff, has_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [OFF_W-1:0]        pend_off_ff, pend_off_in;
   logic [POS_W-1:0]        pend_pos_ff, pend_pos_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [OFF_W-1:0]        rsp_off_ff, rsp_off_in;
   logic [POS_W-1:0]        rsp_pos_ff, rsp_pos_in;
   logic [TOTAL_W-1:0]      rsp_total_ff, rsp_total_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   entry_type     ram_wdata, ram_rdata;

   logic          req_acc, slot_free, after, emit, emit_last;
   logic [CW:0]   mid_sum;
   logic [CW-1:0] mid;
   entry_type     new_entry;

   sit_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_stall = (st_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = mid_sum[CW:1];
   assign new_entry = '{key: key_ff, offset: boff_ff};

   // stored entry sorts after the one being inserted
   always_comb begin
      if (ram_rdata.key != key_ff) begin
         after = ($signed(ram_rdata.key) > $signed(key_ff));
      end else begin
         after = (ram_rdata.offset > boff_ff);
      end
   end

   always_comb begin
      st_in       = st_ff;
      key_in      = key_ff;
      boff_in     = boff_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      n_in        = n_ff;
      has_in      = has_ff;
      status_in   = status_ff;
      pend_off_in = pend_off_ff;
      pend_pos_in = pend_pos_ff;
      ram_we      = 1'b0;
      ram_waddr   = AW'(idx_ff);
      ram_wdata   = new_entry;
      ram_re      = 1'b0;
      ram_raddr   = AW'(idx_ff);
      emit        = 1'b0;
      emit_last   = 1'b0;

      case (st_ff)
         S_IDLE: begin
            if (req_acc) begin
               key_in      = req_key;
               boff_in     = req_byte_offset;
               n_in        = '0;
               has_in      = 1'b0;
               status_in   = ST_OK;
               pend_off_in = '0;
               pend_pos_in = '0;
               case (req_command)
                  CMD_INSERT: begin
                     if (req_key == NULL_KEY) begin
                        status_in = ST_NULL;
                        st_in     = S_FIN;
                     end else if (cnt_ff >= CW'(TABLE_DEPTH)) begin
                        status_in = ST_FULL;
                        st_in     = S_FIN;
                     end else begin
                        idx_in = cnt_ff;
                        st_in  = S_INS_RD;
                     end
                  end
                  CMD_SEARCH: begin
                     lo_in = '0;
                     hi_in = cnt_ff;
                     st_in = S_SRCH_RD;
                  end
                  CMD_DELETE: begin
                     if (XW'(req_position) >= XW'(cnt_ff)) begin
                        status_in = ST_BADPOS;
                        st_in     = S_FIN;
                     end else begin
                        idx_in = CW'(req_position);
                        st_in  = S_DEL_RD;
                     end
                  end
                  default: begin
                     st_in = S_FIN;
                  end
               endcase
            end
         end
         S_INS_RD: begin
            if (idx_ff == '0) begin
               ram_we    = 1'b1;
               ram_waddr = '0;
               cnt_in    = cnt_ff + 1'b1;
               st_in     = S_FIN;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = AW'(idx_ff - 1'b1);
               st_in     = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            ram_we = 1'b1;
            if (after) begin
               ram_wdata = ram_rdata;
               idx_in    = idx_ff - 1'b1;
               st_in     = S_INS_RD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               st_in  = S_FIN;
            end
         end
         S_SRCH_RD: begin
            if (lo_ff == hi_ff) begin
               idx_in = lo_ff;
               st_in  = S_RUN_RD;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = AW'(mid);
               st_in     = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if ($signed(ram_rdata.key) < $signed(key_ff)) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
            end
            st_in = S_SRCH_RD;
         end
         S_RUN_RD: begin
            if ((idx_ff < cnt_ff) && (n_ff < MAX_RESULTS)) begin
               ram_re = 1'b1;
               st_in  = S_RUN_CMP;
            end else begin
               if (!has_ff) begin
                  status_in = ST_NOTFOUND;
               end
               st_in = S_FIN;
            end
         end
         S_RUN_CMP: begin
            if (ram_rdata.key == key_ff) begin
               // a further match means the held one is not the last
               if (!has_ff || slot_free) begin
                  emit        = has_ff;
                  pend_off_in = ram_rdata.offset;
                  pend_pos_in = POS_W'(idx_ff);
                  has_in      = 1'b1;
                  n_in        = n_ff + 1'b1;
                  idx_in      = idx_ff + 1'b1;
                  st_in       = S_RUN_RD;
               end
            end else begin
               if (!has_ff) begin
                  status_in = ST_NOTFOUND;
               end
               st_in = S_FIN;
            end
         end
         S_DEL_RD: begin
            if ((idx_ff + 1'b1) < cnt_ff) begin
               ram_re    = 1'b1;
               ram_raddr = AW'(idx_ff + 1'b1);
               st_in     = S_DEL_WR;
            end else begin
               cnt_in = cnt_ff - 1'b1;
               st_in  = S_FIN;
            end
         end
         S_DEL_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            idx_in    = idx_ff + 1'b1;
            st_in     = S_DEL_RD;
         end
         S_FIN: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_last = 1'b1;
               st_in     = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = emit_last ? status_ff : ST_OK;
         rsp_off_in    = pend_off_ff;
         rsp_pos_in    = pend_pos_ff;
         rsp_total_in  = TOTAL_W'(cnt_ff);
         rsp_last_in   = emit_last;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      boff_ff       <= boff_in;
      idx_ff        <= idx_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      n_ff          <= n_in;
      has_ff        <= has_in;
      status_ff     <= status_in;
      pend_off_ff   <= pend_off_in;
      pend_pos_ff   <= pend_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_match_offset   = rsp_off_ff;
   assign rsp_match_position = rsp_pos_ff;
   assign rsp_entry_total    = rsp_total_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/sit_checker.sv
// port checker for the sorted index table, bound to the top level
// depends on sit_pkg for status codes
`default_nettype none

module sit_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [sit_pkg::STATUS_W-1:0]  rsp_status,
   input wire logic [sit_pkg::OFF_W-1:0]     rsp_match_offset,
   input wire logic [sit_pkg::POS_W-1:0]     rsp_match_position,
   input wire logic [sit_pkg::TOTAL_W-1:0]   rsp_entry_total,
   input wire logic                          rsp_last
);

   import sit_pkg::*;

   // a stalled item holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_match_offset) && $stable(rsp_last))
      else $error("rsp item changed while stalled");

   // error and not-found items end their command
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_last)
      else $error("non-ok item without last");

   // only search matches carry offset and position
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_match_offset == '0)
         && (rsp_match_position == '0))
      else $error("non-ok item carries match data");

   // a search run does not change the entry count
   a_run_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last ##1 rsp_valid
         |-> rsp_entry_total == $past(rsp_entry_total))
      else $error("entry total changed within a run");

endmodule

bind sorted_index_table sit_checker u_sit_checker (.*);

`default_nettype wire
